// ===== rtl/kffra_pkg.sv =====
// ----------------------------------------------------------------------------
// kffra_pkg
// Shared types and codes for the keyed first-fit region allocator.
// ----------------------------------------------------------------------------
package kffra_pkg;

  localparam int KEY_W = 48;
  localparam int OFS_W = 32;

  typedef logic [2:0] status_t;
  localparam status_t ST_PLACED   = 3'd0;
  localparam status_t ST_REPLACED = 3'd1;
  localparam status_t ST_FREED    = 3'd2;
  localparam status_t ST_ABSENT   = 3'd3;
  localparam status_t ST_FULL     = 3'd4;
  localparam status_t ST_RANGE    = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] key_x;
    logic signed [15:0] key_y;
    logic signed [15:0] key_z;
    logic [31:0]        region_bytes;
  } req_t;

  typedef struct packed {
    logic [31:0] region_offset;
    status_t     status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, reset index
    logic idx_clr;    // index back to zero
    logic idx_inc;
    logic idx_dec;
    logic rd_en;      // read slot at index
    logic mark_had;   // key hit at index
    logic rm_mv;      // write slot idx with read data (idx+1 read)
    logic used_dec;
    logic gap_step;   // evaluate slot data for gap search
    logic ins_mv;     // write slot idx with read data (idx-1 read)
    logic ins_put;    // write new region at idx
    logic used_inc;
    logic done;       // present result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic key_hit;
    logic idx_at_used;   // idx >= used
    logic idx_last;      // idx+1 >= used
    logic idx_le_pos;    // idx <= pos
    logic gap_fit;
    logic full;
    logic size_zero;
    logic is_free;
    logic had;
    logic range_bad;     // chosen gap would end past the offset range
  } sts_t;

endpackage

// ===== rtl/kffra_datapath.sv =====
// ----------------------------------------------------------------------------
// kffra_datapath
// Slot memory, index counter, gap search arithmetic and result register.
// ----------------------------------------------------------------------------
module kffra_datapath import kffra_pkg::*; #(
  parameter int MAX_REGIONS = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp,
  output logic rsp_valid
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int SW = KEY_W + 2 * OFS_W;

  logic [SW-1:0] mem [MAX_REGIONS];
  logic [SW-1:0] rd_data;
  logic [CW-1:0] idx, used, pos;
  req_t          r;
  logic          had;
  logic          placed;
  logic [32:0]   cur;
  logic          found;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] wr_data;
  logic          wr_en;
  logic          mv_pend;
  logic [IW-1:0] mv_addr;
  rsp_t          rsp_next;

  logic [KEY_W-1:0] rkey;
  logic [31:0]      rd_ofs, rd_sz;
  logic [33:0]      need;

  assign rkey   = {r.key_z, r.key_y, r.key_x};
  assign rd_ofs = rd_data[2*OFS_W-1:OFS_W];
  assign rd_sz  = rd_data[OFS_W-1:0];
  assign need   = {1'b0, cur} + {2'b0, r.region_bytes};

  // read address: index, or neighbor for shifting moves
  always_comb begin
    rd_addr = idx[IW-1:0];
    if (cmd.rm_mv) rd_addr = IW'(idx + CW'(1));
    if (cmd.ins_mv) rd_addr = IW'(idx - CW'(1));
  end

  always_comb begin
    wr_en   = cmd.ins_put;
    wr_addr = idx[IW-1:0];
    wr_data = {rkey, cur[31:0], r.region_bytes};
  end

  // single write port: a pending move and a new region never share a cycle
  always_ff @(posedge clk) begin
    if (mv_pend) mem[mv_addr] <= rd_data;
    else if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  // moves write the registered read data in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) mv_pend <= 1'b0;
    else mv_pend <= cmd.rm_mv | cmd.ins_mv;
    mv_addr <= idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      idx       <= '0;
      had       <= 1'b0;
      placed    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.done;
      if (cmd.load || cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + CW'(1);
      else if (cmd.idx_dec) idx <= idx - CW'(1);
      if (cmd.load) had <= 1'b0;
      if (cmd.mark_had) had <= 1'b1;
      if (cmd.load) placed <= 1'b0;
      if (cmd.ins_put) placed <= 1'b1;
      if (cmd.used_dec) used <= used - CW'(1);
      if (cmd.used_inc) used <= used + CW'(1);
    end
  end

  always_comb begin
    rsp_next.region_offset = 32'd0;
    if (r.op == OP_FREE) rsp_next.status = had ? ST_FREED : ST_ABSENT;
    else if (r.region_bytes == 32'd0) rsp_next.status = had ? ST_REPLACED : ST_PLACED;
    else if (placed) begin
      rsp_next.status        = had ? ST_REPLACED : ST_PLACED;
      rsp_next.region_offset = cur[31:0];
    end
    else if (used >= CW'(MAX_REGIONS)) rsp_next.status = ST_FULL;
    else rsp_next.status = ST_RANGE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r     <= req;
      cur   <= '0;
      found <= 1'b0;
    end
    if (cmd.idx_clr) begin
      cur   <= '0;
      found <= 1'b0;
      pos   <= used;
    end
    if (cmd.gap_step && !found) begin
      if ({2'b0, rd_ofs} >= need) begin
        found <= 1'b1;
        pos   <= idx;
      end else begin
        cur <= {1'b0, rd_ofs} + {1'b0, rd_sz};
      end
    end
    if (cmd.done) rsp <= rsp_next;
  end

  always_comb begin
    sts.key_hit     = rd_data[SW-1:2*OFS_W] == rkey;
    sts.idx_at_used = idx >= used;
    sts.idx_last    = (idx + CW'(1)) >= used;
    sts.idx_le_pos  = idx <= pos;
    sts.gap_fit     = found || ({2'b0, rd_ofs} >= need);
    sts.full        = used >= CW'(MAX_REGIONS);
    sts.size_zero   = r.region_bytes == 32'd0;
    sts.is_free     = r.op == OP_FREE;
    sts.had         = had;
    sts.range_bad   = need > 34'h1_0000_0000;
  end

endmodule

// ===== rtl/kffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// kffra_ctrl
// Sequencer: key search, removal shift, gap search, insert shift, result.
// ----------------------------------------------------------------------------
module kffra_ctrl import kffra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_KRD   = 11'b00000000010,
    S_KCHK  = 11'b00000000100,
    S_RMV   = 11'b00000001000,
    S_RMW   = 11'b00000010000,
    S_DEC   = 11'b00000100000,
    S_GRD   = 11'b00001000000,
    S_GCHK  = 11'b00010000000,
    S_INS   = 11'b00100000000,
    S_INW   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_KRD;
        end
      end
      S_KRD: begin
        if (sts.idx_at_used) state_next = S_DEC;
        else begin
          cmd.rd_en = 1'b1;
          state_next = S_KCHK;
        end
      end
      S_KCHK: begin
        if (sts.key_hit) begin
          cmd.mark_had = 1'b1;
          state_next = S_RMV;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_KRD;
        end
      end
      S_RMV: begin
        if (sts.idx_last) state_next = S_DEC;
        else begin
          cmd.rm_mv = 1'b1;
          cmd.rd_en = 1'b1;
          state_next = S_RMW;
        end
      end
      S_RMW: begin
        cmd.idx_inc = 1'b1;
        state_next = S_RMV;
      end
      S_DEC: begin
        if (sts.had) cmd.used_dec = 1'b1;
        cmd.idx_clr = 1'b1;
        if (sts.is_free || sts.size_zero) state_next = S_DONE;
        else state_next = S_GRD;
      end
      S_GRD: begin
        if (sts.full) state_next = S_DONE;
        else if (sts.idx_at_used) begin
          if (sts.range_bad) state_next = S_DONE;
          else state_next = S_INS;
        end else begin
          cmd.rd_en = 1'b1;
          state_next = S_GCHK;
        end
      end
      S_GCHK: begin
        cmd.gap_step = 1'b1;
        if (sts.gap_fit) state_next = S_GRD;
        cmd.idx_inc = 1'b1;
        if (!sts.gap_fit) state_next = S_GRD;
      end
      S_INS: begin
        // idx walks from used down to pos, shifting slots up
        if (sts.idx_le_pos) begin
          cmd.ins_put  = 1'b1;
          cmd.used_inc = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.ins_mv  = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.idx_dec = 1'b1;
          state_next = S_INW;
        end
      end
      S_INW: begin
        // moved slot is written this cycle
        state_next = S_INS;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/keyed_first_fit_region_allocator.sv =====
// Key search, removal shift, gap search and insert shift each walk the slot
// memory one entry at a time.
// Throughput: one request at a time; start is taken again in the result cycle.
// Result shows for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
// keyed_first_fit_region_allocator
// Top level: sorted region table with keyed first-fit placement.
// ----------------------------------------------------------------------------
module keyed_first_fit_region_allocator import kffra_pkg::*; #(
  parameter int MAX_REGIONS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  kffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  kffra_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (done)
  );

endmodule

// ===== rtl/kffra_checker.sv =====
// ----------------------------------------------------------------------------
// kffra_port_checks
// Port-level checks on the allocator command interface.
// ----------------------------------------------------------------------------
module kffra_port_checks import kffra_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("beat not taken");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result beat longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status <= ST_RANGE) else $error("bad status");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_PLACED && rsp.status != ST_REPLACED
      |-> rsp.region_offset == 32'd0) else $error("offset without placement");

endmodule

bind keyed_first_fit_region_allocator kffra_port_checks u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ===== dv/kffra_checker.sv =====
// ----------------------------------------------------------------------------
// kffra_checker
// Watches the request and result channels of the region allocator. It keeps
// its own sorted region table, predicts each result and compares it with the
// result the block returns.
// ----------------------------------------------------------------------------
module kffra_checker import kffra_pkg::*; #(
  parameter int MAX_REGIONS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] tbl_key [MAX_REGIONS];
  logic [31:0] tbl_ofs [MAX_REGIONS];
  logic [31:0] tbl_len [MAX_REGIONS];
  int          tbl_used;
  rsp_t        expected_rsp[$];

  function automatic void drop_region(int idx);
    for (int i = idx; i + 1 < tbl_used; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_ofs[i] = tbl_ofs[i + 1];
      tbl_len[i] = tbl_len[i + 1];
    end
    tbl_used--;
  endfunction

  function automatic rsp_t place_region(req_t r);
    logic [47:0] k;
    logic [33:0] cur;
    int          hit;
    int          pos;
    rsp_t        o;
    k = {r.key_z, r.key_y, r.key_x};
    hit = -1;
    o.region_offset = '0;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == k) begin
        hit = i;
        break;
      end
    end
    if (r.op == OP_FREE) begin
      if (hit >= 0) begin
        drop_region(hit);
        o.status = ST_FREED;
      end else begin
        o.status = ST_ABSENT;
      end
      return o;
    end
    // an allocate on a known key always releases the old region first
    if (hit >= 0) drop_region(hit);
    if (r.region_bytes == 0) begin
      o.status = (hit >= 0) ? ST_REPLACED : ST_PLACED;
      return o;
    end
    if (tbl_used >= MAX_REGIONS) begin
      o.status = ST_FULL;
      return o;
    end
    cur = '0;
    pos = tbl_used;
    for (int i = 0; i < tbl_used; i++) begin
      if ({2'b00, tbl_ofs[i]} >= cur + r.region_bytes) begin
        pos = i;
        break;
      end
      cur = {2'b00, tbl_ofs[i]} + tbl_len[i];
    end
    if (cur + r.region_bytes > 34'h1_0000_0000) begin
      o.status = ST_RANGE;
      return o;
    end
    for (int i = tbl_used; i > pos; i--) begin
      tbl_key[i] = tbl_key[i - 1];
      tbl_ofs[i] = tbl_ofs[i - 1];
      tbl_len[i] = tbl_len[i - 1];
    end
    tbl_key[pos] = k;
    tbl_ofs[pos] = cur[31:0];
    tbl_len[pos] = r.region_bytes;
    tbl_used++;
    o.region_offset = cur[31:0];
    o.status = (hit >= 0) ? ST_REPLACED : ST_PLACED;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      tbl_used = 0;
      fails = 0;
      expected_rsp.delete();
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          if (fails < 10) $display("unexpected result beat: ofs=%h st=%0d",
                                   rsp.region_offset, rsp.status);
          fails++;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (rsp.region_offset !== exp_r.region_offset || rsp.status !== exp_r.status) begin
            if (fails < 10)
              $display("result beat differs: exp ofs=%h st=%0d, got ofs=%h st=%0d",
                       exp_r.region_offset, exp_r.status, rsp.region_offset, rsp.status);
            fails++;
          end
        end
      end
      if (start && !busy) expected_rsp = {expected_rsp, place_region(req)};
    end
    pending = expected_rsp.size();
  end

  final_check: assert property (@(posedge clk) 1);
endmodule

// ===== dv/tb_keyed_first_fit_region_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_first_fit_region_allocator
// Drives allocate and free requests from a small key pool so the table fills,
// drains and fragments; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keyed_first_fit_region_allocator;
  import kffra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 4000;
  localparam int N_RANDOM   = 1280;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  int          fails;
  int          pending;
  int          idle_cycles;
  logic [47:0] key_pool [96];

  keyed_first_fit_region_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  kffra_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles without any accepted beat on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("keyed_first_fit_region_allocator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic op, logic [47:0] k, logic [31:0] nbytes);
    req_t r;
    r.op = op;
    r.key_x = k[15:0];
    r.key_y = k[31:16];
    r.key_z = k[47:32];
    r.region_bytes = nbytes;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_bytes();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 32'd16 << $urandom_range(0, 3);
    if (sel < 65) return 32'd0;
    if (sel < 80) return $urandom_range(1, 200);
    if (sel < 90) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  initial begin
    logic [47:0] k;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    for (int i = 0; i < 96; i++) key_pool[i] = 48'({$urandom, $urandom});
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zero size, full range, past range, extreme keys, exact gap
    send(OP_ALLOC, 48'h0001_0002_0003, 32'd0);
    send(OP_ALLOC, 48'h8000_8000_8000, 32'hFFFF_FFFF);
    send(OP_ALLOC, 48'h7FFF_7FFF_7FFF, 32'd1);
    send(OP_FREE,  48'h8000_8000_8000, 32'd0);
    send(OP_FREE,  48'h8000_8000_8000, 32'hFFFF_FFFF);
    send(OP_ALLOC, 48'h7FFF_7FFF_7FFF, 32'd16);
    send(OP_ALLOC, 48'hFFFF_FFFF_FFFF, 32'd16);
    send(OP_ALLOC, 48'h0000_0000_0000, 32'd16);
    send(OP_FREE,  48'hFFFF_FFFF_FFFF, 32'd0);
    send(OP_ALLOC, 48'h1234_5678_9ABC, 32'd16);
    send(OP_ALLOC, 48'h7FFF_7FFF_7FFF, 32'd8);
    send(OP_ALLOC, 48'h0000_0000_0000, 32'd0);
    send(OP_ALLOC, 48'h8000_0000_7FFF, 32'h8000_0000);
    send(OP_ALLOC, 48'h8001_0001_7FFE, 32'h8000_0000);
    send(OP_FREE,  48'h7FFF_7FFF_7FFF, 32'd0);
    send(OP_FREE,  48'h1234_5678_9ABC, 32'd0);
    send(OP_FREE,  48'h8000_0000_7FFF, 32'd0);

    // pool of 96 keys against 64 slots, biased to allocate: table fills up
    for (int n = 0; n < N_RANDOM; n++) begin
      if ((n < 400 || n > 700) && $urandom_range(0, 99) < 6) pause();
      if (n == 650) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) k = 48'({$urandom, $urandom});
      else k = key_pool[$urandom_range(0, 95)];
      if ($urandom_range(0, 99) < 28) send(OP_FREE, k, $urandom);
      else send(OP_ALLOC, k, pick_bytes());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("keyed_first_fit_region_allocator: match");
    end else begin
      $display("keyed_first_fit_region_allocator: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/kffra_pkg.sv
rtl/kffra_datapath.sv
rtl/kffra_ctrl.sv
rtl/keyed_first_fit_region_allocator.sv
rtl/kffra_checker.sv
dv/kffra_checker.sv
dv/tb_keyed_first_fit_region_allocator.sv
